/* rtl/core/rectangle_atlas_placer_defines.svh */
// ---------------------------------------------------------------------------
// rectangle_atlas_placer_defines
// assertion macros of the atlas placer checker
// ---------------------------------------------------------------------------
`ifndef RECTANGLE_ATLAS_PLACER_DEFINES_SVH
`define RECTANGLE_ATLAS_PLACER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RAP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("atlas placer check failed");

// next-cycle implication, disabled during reset
`define RAP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("atlas placer check failed");

`endif

/* rtl/core/rap_pkg.sv */
// ---------------------------------------------------------------------------
// rap_pkg
// types, codes and constants of the rectangle atlas placer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rap_pkg;

  localparam int CoordW      = 13;
  localparam int SumW        = CoordW + 2;
  localparam int OutCoordW   = 12;
  localparam int SlotW       = 6;
  localparam int CfgIdxW     = 2;
  localparam int InDataW     = 32;
  localparam int OutPackW    = 2 * OutCoordW + SlotW;
  localparam int OutDataW    = 32;
  localparam int DefMaxRects = 64;

  localparam logic [CoordW-1:0] DefAtlasWidth  = 13'd1024;
  localparam logic [CoordW-1:0] DefAtlasHeight = 13'd1024;
  localparam logic [CoordW-1:0] DefRowStep     = 13'd1;

  typedef enum logic [CfgIdxW-1:0] {
    RegAtlasWidth  = 2'd0,
    RegAtlasHeight = 2'd1,
    RegRowStep     = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    StsPlaced = 2'd0,
    StsTooBig = 2'd1,
    StsNoFit  = 2'd2,
    StsFull   = 2'd3
  } status_e;

  typedef struct packed {
    logic [CoordW-1:0] h;
    logic [CoordW-1:0] w;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] x;
  } rect_t;

  typedef struct packed {
    logic load;
    logic fail_big;
    logic fail_full;
    logic fail_nofit;
    logic store;
    logic next_row;
    logic next_idx;
    logic jump;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic too_big;
    logic full;
    logic empty;
    logic row_over;
    logic col_over;
    logic scan_end;
    logic overlap;
    logic out_busy;
  } dp_stat_t;

endpackage

/* rtl/core/rap_ctrl.sv */
// ---------------------------------------------------------------------------
// rap_ctrl
// sequencer of the placement search: size checks, row/column walk, table scan
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rap_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rap_pkg::dp_stat_t  stat_i,
  output rap_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StCheck = 6'b000010,
    StFit   = 6'b000100,
    StRead  = 6'b001000,
    StComp  = 6'b010000,
    StDone  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StCheck;
        end
      end
      StCheck: begin
        if (stat_i.too_big) begin
          cmd_o.fail_big = 1'b1;
          state_d        = StDone;
        end else if (stat_i.full) begin
          cmd_o.fail_full = 1'b1;
          state_d         = StDone;
        end else if (stat_i.empty) begin
          cmd_o.store = 1'b1;
          state_d     = StDone;
        end else begin
          state_d = StFit;
        end
      end
      StFit: begin
        if (stat_i.row_over) begin
          cmd_o.fail_nofit = 1'b1;
          state_d          = StDone;
        end else if (stat_i.col_over) begin
          cmd_o.next_row = 1'b1;
        end else begin
          state_d = StRead;
        end
      end
      StRead: begin
        if (stat_i.scan_end) begin
          cmd_o.store = 1'b1;
          state_d     = StDone;
        end else begin
          state_d = StComp;
        end
      end
      StComp: begin
        if (stat_i.overlap) begin
          cmd_o.jump = 1'b1;
          state_d    = StFit;
        end else begin
          cmd_o.next_idx = 1'b1;
          state_d        = StRead;
        end
      end
      StDone: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/core/rap_datapath.sv */
// ---------------------------------------------------------------------------
// rap_datapath
// config registers, rectangle table, overlap compare and result registers
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rap_datapath #(
  parameter int MaxRects = rap_pkg::DefMaxRects
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rap_pkg::ctrl_cmd_t               cmd_i,
  output rap_pkg::dp_stat_t                stat_o,
  input  logic                             cfg_valid_i,
  input  logic [rap_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [rap_pkg::CoordW-1:0]       cfg_data_i,
  input  logic [rap_pkg::CoordW-1:0]       rect_width_i,
  input  logic [rap_pkg::CoordW-1:0]       rect_height_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [1:0]                       status_o,
  output logic [rap_pkg::OutCoordW-1:0]    place_x_o,
  output logic [rap_pkg::OutCoordW-1:0]    place_y_o,
  output logic [rap_pkg::SlotW-1:0]        slot_index_o
);

  localparam int IdxW   = (MaxRects > 1) ? $clog2(MaxRects) : 1;
  localparam int CntW   = $clog2(MaxRects + 1);
  localparam int CoordW = rap_pkg::CoordW;
  localparam int SumW   = rap_pkg::SumW;

  logic [CoordW-1:0] aw_q, ah_q, step_q;
  logic [CoordW-1:0] w_q, h_q;
  logic [CoordW:0]   x_q, y_q;
  logic [CntW-1:0]   count_q, idx_q;

  rap_pkg::rect_t mem_q [MaxRects];
  rap_pkg::rect_t rd_q;
  rap_pkg::rect_t wr_entry;

  rap_pkg::status_e                res_status_q, out_status_q;
  logic [rap_pkg::OutCoordW-1:0]   res_x_q, res_y_q, out_x_q, out_y_q;
  logic [rap_pkg::SlotW-1:0]       res_slot_q, out_slot_q;
  logic                            out_valid_q;

  logic [CoordW-1:0] step_eff;
  logic [SumW-1:0]   x_end, y_end, bx_end, by_end;
  logic [15:0]       cnt_ext;

  // config writes, always ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aw_q   <= rap_pkg::DefAtlasWidth;
      ah_q   <= rap_pkg::DefAtlasHeight;
      step_q <= rap_pkg::DefRowStep;
    end else if (cfg_valid_i) begin
      unique case (rap_pkg::cfg_reg_e'(cfg_index_i))
        rap_pkg::RegAtlasWidth:  aw_q   <= cfg_data_i;
        rap_pkg::RegAtlasHeight: ah_q   <= cfg_data_i;
        rap_pkg::RegRowStep:     step_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign step_eff = (step_q == '0) ? CoordW'(1) : step_q;
  assign x_end    = SumW'(x_q) + SumW'(w_q);
  assign y_end    = SumW'(y_q) + SumW'(h_q);
  assign bx_end   = SumW'(rd_q.x) + SumW'(rd_q.w);
  assign by_end   = SumW'(rd_q.y) + SumW'(rd_q.h);
  assign cnt_ext  = 16'(count_q);

  assign stat_o.too_big  = (w_q > aw_q) || (h_q > ah_q);
  assign stat_o.full     = (count_q == CntW'(MaxRects));
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.row_over = (y_end > SumW'(ah_q));
  assign stat_o.col_over = (x_end > SumW'(aw_q));
  assign stat_o.scan_end = (idx_q == count_q);
  assign stat_o.overlap  = (SumW'(x_q) < bx_end) && (x_end > SumW'(rd_q.x)) &&
                           (SumW'(y_q) < by_end) && (y_end > SumW'(rd_q.y));
  assign stat_o.out_busy = out_valid_q && !out_ready_i;

  // search position and table walk
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      w_q   <= rect_width_i;
      h_q   <= rect_height_i;
      x_q   <= '0;
      y_q   <= '0;
      idx_q <= '0;
    end else if (cmd_i.next_row) begin
      y_q   <= y_q + (CoordW+1)'(step_eff);
      x_q   <= '0;
      idx_q <= '0;
    end else if (cmd_i.jump) begin
      x_q   <= bx_end[CoordW:0];
      idx_q <= '0;
    end else if (cmd_i.next_idx) begin
      idx_q <= idx_q + CntW'(1);
    end
  end

  // pending result
  always_ff @(posedge clk_i) begin
    if (cmd_i.fail_big || cmd_i.fail_full || cmd_i.fail_nofit) begin
      res_x_q    <= '0;
      res_y_q    <= '0;
      res_slot_q <= '0;
      if (cmd_i.fail_big) begin
        res_status_q <= rap_pkg::StsTooBig;
      end else if (cmd_i.fail_full) begin
        res_status_q <= rap_pkg::StsFull;
      end else begin
        res_status_q <= rap_pkg::StsNoFit;
      end
    end else if (cmd_i.store) begin
      res_status_q <= rap_pkg::StsPlaced;
      res_x_q      <= x_q[rap_pkg::OutCoordW-1:0];
      res_y_q      <= y_q[rap_pkg::OutCoordW-1:0];
      res_slot_q   <= cnt_ext[rap_pkg::SlotW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.store) begin
      count_q <= count_q + CntW'(1);
    end
  end

  // rectangle table
  assign wr_entry.x = x_q[CoordW-1:0];
  assign wr_entry.y = y_q[CoordW-1:0];
  assign wr_entry.w = w_q;
  assign wr_entry.h = h_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      mem_q[count_q[IdxW-1:0]] <= wr_entry;
    end
    rd_q <= mem_q[idx_q[IdxW-1:0]];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_q <= res_status_q;
      out_x_q      <= res_x_q;
      out_y_q      <= res_y_q;
      out_slot_q   <= res_slot_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign place_x_o    = out_x_q;
  assign place_y_o    = out_y_q;
  assign slot_index_o = out_slot_q;

endmodule

/* rtl/core/rectangle_atlas_placer.sv */
// ---------------------------------------------------------------------------
// rectangle_atlas_placer
// first-fit placement of rectangles into a 2D atlas with a table of placed boxes
// ---------------------------------------------------------------------------
//  channel   dir  tdata / payload (low bits first)          tuser
//  s_axis    in   rect_width[12:0], rect_height[25:13]     -
//  m_axis    out  place_x[11:0], place_y[23:12], slot[29:24] status[1:0]
//  cfg       in   cfg_index_i selects register, cfg_data_i value
//
//  rejects by size or a full table and the first rectangle go from the
//  check state straight to done; otherwise each candidate spot reads the
//  table entry by entry through the single read port, a spot that fits is
//  stored after the end-of-table check and a row change is its own step
//  one request at a time; the next input beat is taken while a result waits
//  reset clears the table count, config registers go to their defaults
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rectangle_atlas_placer #(
  parameter int MaxRects = rap_pkg::DefMaxRects
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // rect_width, rect_height
  input  logic [rap_pkg::InDataW-1:0]     s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // place_x, place_y, slot_index
  output logic [rap_pkg::OutDataW-1:0]    m_axis_tdata,
  // status
  output logic [1:0]                      m_axis_tuser,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rap_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [rap_pkg::CoordW-1:0]      cfg_data_i
);

  rap_pkg::ctrl_cmd_t cmd;
  rap_pkg::dp_stat_t  stat;

  logic [rap_pkg::OutCoordW-1:0] place_x, place_y;
  logic [rap_pkg::SlotW-1:0]     slot_index;

  assign cfg_ready_o = 1'b1;

  rap_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rap_datapath #(
    .MaxRects (MaxRects)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .rect_width_i  (s_axis_tdata[rap_pkg::CoordW-1:0]),
    .rect_height_i (s_axis_tdata[2*rap_pkg::CoordW-1:rap_pkg::CoordW]),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .status_o      (m_axis_tuser),
    .place_x_o     (place_x),
    .place_y_o     (place_y),
    .slot_index_o  (slot_index)
  );

  assign m_axis_tdata = {{(rap_pkg::OutDataW - rap_pkg::OutPackW){1'b0}},
                         slot_index, place_y, place_x};

endmodule

/* rtl/core/rap_checker.sv */
// ---------------------------------------------------------------------------
// rap_checker
// port-level checks of the atlas placer, bound to the top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rectangle_atlas_placer_defines.svh"

module rap_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [rap_pkg::OutDataW-1:0]    m_axis_tdata,
  input logic [1:0]                      m_axis_tuser
);

  // failed requests carry no position or slot
  `RAP_ASSERT_NOW(a_fail_zero, m_axis_tvalid && (m_axis_tuser != rap_pkg::StsPlaced), m_axis_tdata == '0)

  // a waiting result holds
  `RAP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // one request in flight
  `RAP_ASSERT_NEXT(a_one_inflight, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // no result can come out the cycle after an accept
  `RAP_ASSERT_NEXT(a_min_latency, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid))

endmodule

bind rectangle_atlas_placer rap_checker u_rap_checker (.*);
